FILE: hw/rtl/freeze_thaw_front_finder_defines.svh
// Assertion macros shared by the freeze/thaw front finder checker.
`ifndef FREEZE_THAW_FRONT_FINDER_DEFINES_SVH
`define FREEZE_THAW_FRONT_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTHF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fthf: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fthf: next-cycle property failed");

`endif

FILE: hw/rtl/fthf_pkg.sv
// Types and constants of the freeze/thaw front finder.
package fthf_pkg;

	// Width of temperatures, depths and the interpolation operands.
	localparam int DATA_W = 16;
	// Width of the per-kind front counters.
	localparam int CNT_W = 5;
	// Width of the list position of a front.
	localparam int SLOT_W = 4;

	// Front kinds as they appear on the result beat.
	localparam logic KIND_THAW   = 1'b0;
	localparam logic KIND_FREEZE = 1'b1;

	// Control sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN
	} fthf_state_t;

	// Request to the serial interpolation unit: floor(mult * scale / div), mult <= div.
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] mult;
		logic [DATA_W-1:0] scale;
		logic [DATA_W-1:0] div;
	} fthf_req_t;

	// Magnitude of a two's complement value as an unsigned number.
	function automatic logic [DATA_W-1:0] fthf_abs(input logic [DATA_W-1:0] v);
		fthf_abs = v[DATA_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

FILE: hw/rtl/freeze_thaw_front_finder.sv
// Freeze/thaw front finder top level: front detection, counters and result register.
//
//  channel | beat fields                                          | handshake
//  s_*     | tdata: node_temp, node_depth; tlast: last_node        | s_tvalid/s_tready
//  m_*     | tdata: depth, slot, totals; tuser: found, kind; tlast | m_tvalid/m_tready
//
// A node without a front goes straight to ST_FIN; a node with a front waits in ST_CALC
// for the serial divider that retires one bit of the depth span per cycle.
// Reset clears the previous node, both front counters and all handshake state.
// A new node is taken while the last result still waits in the output register;
// a finished result waits in its own state while the output stays stalled.
module freeze_thaw_front_finder #(
	parameter int MAX_FRONT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] node_temp, [31:16] node_depth
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] front_depth, [19:16] front_slot,
	                              // [24:20] thaw_total, [29:25] freeze_total, [31:30] zero
	output logic [1:0]  m_tuser,  // [0] front_found, [1] front_kind
	output logic        m_tlast
);
	import fthf_pkg::*;

	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRONT_COUNT);

	fthf_state_t state_q;
	fthf_state_t state_nxt;

	// Profile state.
	logic [DATA_W-1:0] prev_temp_q;
	logic [DATA_W-1:0] prev_depth_q;
	logic              have_prev_q;
	logic [CNT_W-1:0]  thaw_cnt_q;
	logic [CNT_W-1:0]  frz_cnt_q;

	// Item held while its depth is worked out.
	logic              found_q;
	logic              kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  thaw_tot_q;
	logic [CNT_W-1:0]  frz_tot_q;
	logic              last_q;
	logic [DATA_W-1:0] zs_q;
	logic              neg_q;

	// Output register.
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;
	logic              m_tlast_q;

	logic              accept;
	logic              load_out;
	logic [DATA_W-1:0] t_in;
	logic [DATA_W-1:0] z_in;
	logic              t_pos;
	logic              t_neg;
	logic              pt_le0;
	logic              pt_ge0;
	logic              is_thaw;
	logic              is_frz;
	logic              found;
	logic [CNT_W-1:0]  thaw_nxt;
	logic [CNT_W-1:0]  frz_nxt;
	logic              span_neg;
	logic [DATA_W-1:0] span;
	logic [DATA_W-1:0] depth_res;
	fthf_req_t         req;
	logic              div_done;
	logic [DATA_W-1:0] quot;

	assign accept = s_tvalid && s_tready;
	assign t_in   = s_tdata[DATA_W-1:0];
	assign z_in   = s_tdata[2*DATA_W-1:DATA_W];

	// Front decision on the incoming node against the deeper one.
	always_comb begin
		t_pos    = !t_in[DATA_W-1] && (t_in != '0);
		t_neg    = t_in[DATA_W-1];
		pt_le0   = prev_temp_q[DATA_W-1] || (prev_temp_q == '0);
		pt_ge0   = !prev_temp_q[DATA_W-1];
		is_thaw  = have_prev_q && t_pos && pt_le0 && (thaw_cnt_q < MaxCnt);
		is_frz   = have_prev_q && !is_thaw && t_neg && pt_ge0 && (frz_cnt_q < MaxCnt);
		found    = is_thaw || is_frz;
		thaw_nxt = thaw_cnt_q + CNT_W'(is_thaw);
		frz_nxt  = frz_cnt_q + CNT_W'(is_frz);
		span_neg = prev_depth_q < z_in;
		span     = span_neg ? (z_in - prev_depth_q) : (prev_depth_q - z_in);
	end

	// Interpolation request: |t| * |zd - zs| / (|t| + |pt|).
	always_comb begin
		req.start = accept && found;
		req.mult  = fthf_abs(t_in);
		req.scale = span;
		req.div   = fthf_abs(t_in) + fthf_abs(prev_temp_q);
	end

	fthf_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (div_done),
		.quot   (quot)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nxt = found ? ST_CALC : ST_FIN;
			ST_CALC: if (div_done) state_nxt = ST_FIN;
			ST_FIN:  if (load_out) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		load_out = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Profile state update; the last node clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_temp_q  <= '0;
			prev_depth_q <= '0;
			have_prev_q  <= 1'b0;
			thaw_cnt_q   <= '0;
			frz_cnt_q    <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				prev_temp_q  <= '0;
				prev_depth_q <= '0;
				have_prev_q  <= 1'b0;
				thaw_cnt_q   <= '0;
				frz_cnt_q    <= '0;
			end else begin
				prev_temp_q  <= t_in;
				prev_depth_q <= z_in;
				have_prev_q  <= 1'b1;
				thaw_cnt_q   <= thaw_nxt;
				frz_cnt_q    <= frz_nxt;
			end
		end
	end

	// Capture of the accepted node's result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q    <= found;
			kind_q     <= is_frz ? KIND_FREEZE : KIND_THAW;
			slot_q     <= is_frz ? frz_cnt_q[SLOT_W-1:0] :
			              (is_thaw ? thaw_cnt_q[SLOT_W-1:0] : '0);
			thaw_tot_q <= thaw_nxt;
			frz_tot_q  <= frz_nxt;
			last_q     <= s_tlast;
			zs_q       <= z_in;
			neg_q      <= span_neg;
		end
	end

	// The quotient never exceeds the span, so the depth stays between the nodes.
	assign depth_res = !found_q ? '0 : (neg_q ? (zs_q - quot) : (zs_q + quot));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {2'b00, frz_tot_q, thaw_tot_q, slot_q, depth_res};
			m_tuser_q <= {kind_q, found_q};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: hw/rtl/fthf_serdiv.sv
// Bit-serial scaled divider: floor(mult * scale / div), one bit of scale per cycle.
module fthf_serdiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fthf_pkg::fthf_req_t         req,
	output logic                        done,
	output logic [fthf_pkg::DATA_W-1:0] quot
);
	import fthf_pkg::*;

	localparam int CW = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DATA_W-1:0] mult_q;
	logic [DATA_W-1:0] scale_q;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quot_q;

	logic [DATA_W+1:0] acc;
	logic [DATA_W+1:0] div1;
	logic [DATA_W+1:0] div2;
	logic [DATA_W+1:0] rem_nxt;
	logic [1:0]        digit;

	// One step: remainder doubles, adds mult when the scale bit is set, then
	// at most two subtractions of the divisor keep it below the divisor.
	always_comb begin
		acc  = {1'b0, rem_q, 1'b0} + {2'b00, (scale_q[DATA_W-1] ? mult_q : '0)};
		div1 = {2'b00, div_q};
		div2 = {1'b0, div_q, 1'b0};
		priority if (acc >= div2) begin
			digit   = 2'd2;
			rem_nxt = acc - div2;
		end else if (acc >= div1) begin
			digit   = 2'd1;
			rem_nxt = acc - div1;
		end else begin
			digit   = 2'd0;
			rem_nxt = acc;
		end
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			mult_q  <= req.mult;
			scale_q <= req.scale;
			div_q   <= req.div;
			rem_q   <= '0;
			quot_q  <= '0;
		end else if (busy_q) begin
			scale_q <= {scale_q[DATA_W-2:0], 1'b0};
			rem_q   <= rem_nxt[DATA_W-1:0];
			quot_q  <= {quot_q[DATA_W-2:0], 1'b0} + {{(DATA_W-2){1'b0}}, digit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: hw/rtl/fthf_checker.sv
// Port-level checker of the freeze/thaw front finder and its bind statement.
`include "freeze_thaw_front_finder_defines.svh"

module fthf_checker #(
	parameter int MAX_FRONT_COUNT = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import fthf_pkg::*;

	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FRONT_COUNT);

	logic       stalled;
	logic       thaw_beat;
	logic       frz_beat;
	logic [4:0] slot5;

	assign stalled   = m_tvalid && !m_tready;
	assign thaw_beat = m_tvalid && m_tuser[0] && (m_tuser[1] == KIND_THAW);
	assign frz_beat  = m_tvalid && m_tuser[0] && (m_tuser[1] == KIND_FREEZE);
	assign slot5     = {1'b0, m_tdata[19:16]};

	// A stalled result beat holds its contents.
	`FTHF_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// Each node is worked on alone: the input closes after every accepted beat.
	`FTHF_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// A beat without a front carries no kind, depth or slot.
	`FTHF_ASSERT_NOW(a_no_front_clean, clk, arst_n, m_tvalid && !m_tuser[0], (m_tuser[1] == KIND_THAW) && (m_tdata[19:0] == 20'd0))

	// A reported front sits inside its kind's count.
	`FTHF_ASSERT_NOW(a_slot_in_list, clk, arst_n, thaw_beat || frz_beat, (thaw_beat && (slot5 < m_tdata[24:20])) || (frz_beat && (slot5 < m_tdata[29:25])))

	// Totals never pass the list capacity.
	`FTHF_ASSERT_NOW(a_total_cap, clk, arst_n, m_tvalid, (m_tdata[24:20] <= MaxCnt) && (m_tdata[29:25] <= MaxCnt))

endmodule

bind freeze_thaw_front_finder fthf_checker #(.MAX_FRONT_COUNT(MAX_FRONT_COUNT)) u_fthf_checker (.*);

FILE: tb/freeze_thaw_front_finder_checker.sv
// Scoreboard for the freeze/thaw front finder: predicts each result beat and compares it.
`timescale 1ns / 100ps

module freeze_thaw_front_finder_checker #(
	parameter int MAX_FRONT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] node_temp, [31:16] node_depth
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [15:0] front_depth, [19:16] front_slot,
	                              // [24:20] thaw_total, [29:25] freeze_total
	input  logic [1:0]  m_tuser,  // [0] front_found, [1] front_kind
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);
	import fthf_pkg::*;

	typedef struct packed {
		logic              found;
		logic              kind;
		logic [DATA_W-1:0] depth;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  thaw_total;
		logic [CNT_W-1:0]  freeze_total;
		logic              profile_end;
	} front_result_t;

	// Results predicted for accepted nodes, oldest first.
	front_result_t expected_fronts[$];

	// Deeper node of the current pair and the per-profile front counters.
	logic signed [DATA_W-1:0] deep_temp  = '0;
	logic [DATA_W-1:0]        deep_depth = '0;
	logic                     deep_valid = 1'b0;
	logic [CNT_W-1:0]         thaw_seen  = '0;
	logic [CNT_W-1:0]         freeze_seen = '0;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Depth of the zero crossing between a shallow and a deep node, truncated toward zero.
	function automatic logic [DATA_W-1:0] zero_crossing_depth(
		input logic signed [DATA_W-1:0] shallow_t,
		input logic [DATA_W-1:0]        shallow_z,
		input logic signed [DATA_W-1:0] deep_t,
		input logic [DATA_W-1:0]        deep_z
	);
		longint span;
		longint divisor;
		longint offset;
		longint sum;
		span = -longint'(shallow_t) * (longint'(deep_z) - longint'(shallow_z));
		divisor = longint'(deep_t) - longint'(shallow_t);
		offset = (divisor == 0) ? 0 : span / divisor;
		sum = longint'(shallow_z) + offset;
		if (sum < 0)
			sum = 0;
		if (sum > 65535)
			sum = 65535;
		return sum[DATA_W-1:0];
	endfunction

	// Works out the result of one node and advances the profile state.
	task automatic predict_node(
		input logic signed [DATA_W-1:0] temp,
		input logic [DATA_W-1:0]        depth,
		input logic                     last
	);
		front_result_t res;
		res = '0;
		if (deep_valid) begin
			if (temp > 0 && deep_temp <= 0 && thaw_seen < MAX_FRONT_COUNT) begin
				res.found = 1'b1;
				res.kind = KIND_THAW;
				res.depth = zero_crossing_depth(temp, depth, deep_temp, deep_depth);
				res.slot = thaw_seen[SLOT_W-1:0];
				thaw_seen = thaw_seen + 1'b1;
			end else if (temp < 0 && deep_temp >= 0 && freeze_seen < MAX_FRONT_COUNT) begin
				res.found = 1'b1;
				res.kind = KIND_FREEZE;
				res.depth = zero_crossing_depth(temp, depth, deep_temp, deep_depth);
				res.slot = freeze_seen[SLOT_W-1:0];
				freeze_seen = freeze_seen + 1'b1;
			end
		end
		res.thaw_total = thaw_seen;
		res.freeze_total = freeze_seen;
		res.profile_end = last;
		expected_fronts.push_back(res);

		// The shallowest node closes the profile and clears everything.
		if (last) begin
			deep_temp = '0;
			deep_depth = '0;
			deep_valid = 1'b0;
			thaw_seen = '0;
			freeze_seen = '0;
		end else begin
			deep_temp = temp;
			deep_depth = depth;
			deep_valid = 1'b1;
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Input beats are predicted before output beats are checked in the same cycle.
	always @(posedge clk) begin
		front_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_node(s_tdata[15:0], s_tdata[31:16], s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_fronts.size() == 0) begin
					$error("result beat with no node waiting for it");
					fail_count++;
				end else begin
					want = expected_fronts.pop_front();
					check_field("front_found", want.found, m_tuser[0]);
					check_field("front_kind", want.kind, m_tuser[1]);
					check_field("front_depth", want.depth, m_tdata[15:0]);
					check_field("front_slot", want.slot, m_tdata[19:16]);
					check_field("thaw_total", want.thaw_total, m_tdata[24:20]);
					check_field("freeze_total", want.freeze_total, m_tdata[29:25]);
					check_field("profile_end", want.profile_end, m_tlast);
				end
			end
			pending <= expected_fronts.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the freeze/thaw front finder testbench: clock, reset, node stimulus and verdict.
`timescale 1ns / 100ps

module testbench;

	localparam int FRONT_LIMIT  = 4;
	localparam int RANDOM_NODES = 1280;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_START   = 4000;
	localparam int HOLD_CYCLES  = 400;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	int          fail_count;
	int          pending;
	int          quiet_cycles;
	bit          calm;

	freeze_thaw_front_finder #(
		.MAX_FRONT_COUNT(FRONT_LIMIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	freeze_thaw_front_finder_checker #(
		.MAX_FRONT_COUNT(FRONT_LIMIT)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 100 MHz clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offers one node and holds it until the block takes the beat.
	task automatic send_node(
		input logic signed [15:0] temp,
		input logic [15:0]        depth,
		input logic               last
	);
		while (!calm && $urandom_range(0, 99) < 20) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {depth, temp};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Result side: random backpressure, plus one long hold-off while nodes keep coming.
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
				m_tready <= 1'b0;
			else if (calm)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 20);
		end
	end

	// Ends the run when neither side has moved a beat for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("freeze_thaw_front_finder regression: fail");
			$finish;
		end
	end

	initial begin
		int sent;
		int nodes;
		int step;
		logic signed [15:0] temp;
		logic [15:0] depth;
		logic [15:0] mag;
		bit warm;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		calm = 1'b0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// One long profile: extreme temperatures, zero-degree nodes, out-of-order
		// depths, and both lists running full before the shallowest node.
		send_node(16'sh8000, 16'hFFFF, 1'b0);
		send_node(16'sh7FFF, 16'd60000, 1'b0);
		send_node(-16'sd1, 16'd0, 1'b0);
		send_node(16'sd0, 16'd1000, 1'b0);
		send_node(16'sd1, 16'd2000, 1'b0);
		send_node(16'sd0, 16'd1500, 1'b0);
		send_node(-16'sd256, 16'd1200, 1'b0);
		send_node(16'sd256, 16'd1000, 1'b0);
		send_node(-16'sd256, 16'd900, 1'b0);
		send_node(16'sd256, 16'd800, 1'b0);
		send_node(-16'sd256, 16'd700, 1'b0);
		send_node(16'sd256, 16'd600, 1'b0);
		send_node(-16'sd256, 16'd500, 1'b0);
		send_node(16'sh7FFF, 16'd0, 1'b1);
		// A profile of a single node.
		send_node(16'sd5, 16'd100, 1'b1);
		// Full-scale thaw across the whole depth range, depths reversed.
		send_node(16'sh8000, 16'd0, 1'b0);
		send_node(16'sh7FFF, 16'hFFFF, 1'b1);
		// The first node after a profile end must not pair with the old one.
		send_node(16'sh7FFF, 16'hFFFF, 1'b0);
		send_node(16'sh8000, 16'd0, 1'b0);
		send_node(-16'sd5, 16'd10, 1'b1);

		// Random profiles: mostly sign-alternating nodes walking up toward the surface.
		sent = 0;
		warm = 1'b0;
		while (sent < RANDOM_NODES) begin
			nodes = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
			depth = 16'($urandom);
			for (int k = 0; k < nodes; k++) begin
				calm = (sent >= 500 && sent < 700);
				case ($urandom_range(0, 9))
					0: temp = 16'($urandom);
					1: temp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					2: temp = '0;
					default: begin
						if ($urandom_range(0, 3) != 0)
							warm = !warm;
						mag = 16'($urandom_range(1, 4000));
						temp = warm ? signed'(mag) : -signed'(mag);
					end
				endcase
				if ($urandom_range(0, 7) == 0) begin
					depth = 16'($urandom);
				end else begin
					step = $urandom_range(0, 4000);
					depth = (int'(depth) > step) ? 16'(int'(depth) - step) : '0;
				end
				send_node(temp, depth, k == nodes - 1);
				sent++;
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// Drain: wait for every predicted result, then a little past the slowest node.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("freeze_thaw_front_finder regression: pass");
		else
			$display("freeze_thaw_front_finder regression: fail");
		$finish;
	end

endmodule
